// ===== design/msb_pkg.sv =====
// ----------------------------------------------------------------------------
// Masked sprite blitter package
// Register indexes, reset values, field widths and mode bits shared by the
// blitter RTL.
// ----------------------------------------------------------------------------
package msb_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CLIP_LEFT     = 3'd0,
		REG_CLIP_TOP      = 3'd1,
		REG_CLIP_RIGHT    = 3'd2,
		REG_CLIP_BOTTOM   = 3'd3,
		REG_SPRITE_WIDTH  = 3'd4,
		REG_SPRITE_HEIGHT = 3'd5,
		REG_DRAW_MODE     = 3'd6,
		REG_COLOR_BANK    = 3'd7
	} cfg_idx_t;

	localparam int CFG_DATA_W   = 13;
	localparam int CLIP_LO_W    = 12;
	localparam int CLIP_HI_W    = 13;
	localparam int SIDE_REG_W   = 11;
	localparam int MODE_W       = 3;
	localparam int BANK_W       = 8;
	localparam int PIXEL_W      = 8;
	localparam int ORIGIN_W     = 16;
	localparam int DEST_W       = 12;
	// origin, minus half a sprite, plus an offset: room for sides up to 4096
	localparam int COORD_W      = ORIGIN_W + 2;

	localparam int DEF_MAX_SPRITE_SIDE = 1024;

	localparam logic [CLIP_HI_W-1:0]  CLIP_HI_RESET = 13'd4096;
	localparam logic [SIDE_REG_W-1:0] SIDE_RESET    = 11'd1;

	// draw_mode bits
	localparam int MODE_CENTER = 0;
	localparam int MODE_COLOR  = 1;
	localparam int MODE_BLANK  = 2;

	// pixels below this index take the bank remap
	localparam logic [PIXEL_W-1:0] REMAP_LIMIT = 8'd16;

endpackage

// ===== design/masked_sprite_blitter_unit.sv =====
// ----------------------------------------------------------------------------
// Masked sprite blitter
// Places raster-order sprite pixels at origin plus offset, with clipping,
// transparency masking, optional centring, bank remap and blanking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one sprite pixel per
//   transaction with the draw origin. Pixels come in raster order; internal
//   column and row counters give each its offset inside the sprite.
//   Output channel (out_valid / out_stall) carries one destination write per
//   transaction: dest_x, dest_y, value. Clipped pixels, and transparent (zero)
//   pixels unless blanking is on, give no output transaction but still advance the counters.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no pixel is in flight.
//   Pipeline: an accepted pixel goes to the input register, then to the
//   result register, which drives out_valid. Throughput: one pixel per
//   cycle while the output is not stalled, set by the single
//   add-and-compare pass between those two registers.
//   A stall on the output holds the result register; the input register
//   then fills and in_stall rises, so nothing is lost or repeated.
//   Reset: counters at zero, clip window the whole 4096 x 4096 frame,
//   sprite 1 x 1, all modes off. No clearing pass; ready straight away.
// ----------------------------------------------------------------------------
module masked_sprite_blitter_unit #(
	parameter int MAX_SPRITE_SIDE = msb_pkg::DEF_MAX_SPRITE_SIDE
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  msb_pkg::cfg_idx_t                    cfg_index,
	input  logic [msb_pkg::CFG_DATA_W-1:0]       cfg_data,
	// pixel input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [msb_pkg::PIXEL_W-1:0]          pixel,
	input  logic signed [msb_pkg::ORIGIN_W-1:0]  origin_x,
	input  logic signed [msb_pkg::ORIGIN_W-1:0]  origin_y,
	// destination writes
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [msb_pkg::DEST_W-1:0]           dest_x,
	output logic [msb_pkg::DEST_W-1:0]           dest_y,
	output logic [msb_pkg::PIXEL_W-1:0]          value
);
	import msb_pkg::*;

	// counter width, effective side width, and width for the saturation compare
	localparam int CW   = $clog2(MAX_SPRITE_SIDE);
	localparam int EW   = $clog2(MAX_SPRITE_SIDE + 1);
	localparam int CMPW = (EW > SIDE_REG_W) ? EW : SIDE_REG_W;

	// ---------------------------------------------------------------- config
	logic [CLIP_LO_W-1:0]  clip_left_q, clip_top_q;
	logic [CLIP_HI_W-1:0]  clip_right_q, clip_bottom_q;
	logic [SIDE_REG_W-1:0] sprite_width_q, sprite_height_q;
	logic [MODE_W-1:0]     draw_mode_q;
	logic [BANK_W-1:0]     color_bank_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q     <= '0;
			clip_top_q      <= '0;
			clip_right_q    <= CLIP_HI_RESET;
			clip_bottom_q   <= CLIP_HI_RESET;
			sprite_width_q  <= SIDE_RESET;
			sprite_height_q <= SIDE_RESET;
			draw_mode_q     <= '0;
			color_bank_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CLIP_LEFT:     clip_left_q     <= cfg_data[CLIP_LO_W-1:0];
				REG_CLIP_TOP:      clip_top_q      <= cfg_data[CLIP_LO_W-1:0];
				REG_CLIP_RIGHT:    clip_right_q    <= cfg_data[CLIP_HI_W-1:0];
				REG_CLIP_BOTTOM:   clip_bottom_q   <= cfg_data[CLIP_HI_W-1:0];
				REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data[SIDE_REG_W-1:0];
				REG_SPRITE_HEIGHT: sprite_height_q <= cfg_data[SIDE_REG_W-1:0];
				REG_DRAW_MODE:     draw_mode_q     <= cfg_data[MODE_W-1:0];
				REG_COLOR_BANK:    color_bank_q    <= cfg_data[BANK_W-1:0];
				default:           clip_left_q     <= clip_left_q;
			endcase
		end
	end

	// Effective sides: zero reads as one, anything past the maximum saturates.
	logic [EW-1:0] eff_w, eff_h;

	always_comb begin
		if (sprite_width_q == '0) begin
			eff_w = EW'(1);
		end else if (CMPW'(sprite_width_q) > CMPW'(MAX_SPRITE_SIDE)) begin
			eff_w = EW'(MAX_SPRITE_SIDE);
		end else begin
			eff_w = EW'(sprite_width_q);
		end
		if (sprite_height_q == '0) begin
			eff_h = EW'(1);
		end else if (CMPW'(sprite_height_q) > CMPW'(MAX_SPRITE_SIDE)) begin
			eff_h = EW'(MAX_SPRITE_SIDE);
		end else begin
			eff_h = EW'(sprite_height_q);
		end
	end

	// -------------------------------------------------------------- counters
	// Stepped on every accepted pixel; a counter left past a shrunken bound
	// is used once as is and then wraps.
	logic [CW-1:0] col_q, row_q;
	logic [EW:0]   col_inc, row_inc;
	logic          col_wrap, row_wrap;
	logic          in_acc;

	assign in_acc   = in_valid && !in_stall;
	assign col_inc  = (EW+1)'(col_q) + (EW+1)'(1);
	assign row_inc  = (EW+1)'(row_q) + (EW+1)'(1);
	assign col_wrap = col_inc >= (EW+1)'(eff_w);
	assign row_wrap = row_inc >= (EW+1)'(eff_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : CW'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	// ------------------------------------------------------- stage 1: input
	logic                vld_s1;
	logic [PIXEL_W-1:0]  pix_s1;
	logic [ORIGIN_W-1:0] ox_s1, oy_s1;
	logic [CW-1:0]       col_s1, row_s1;
	logic                s2_free;

	assign s2_free  = !out_valid || !out_stall;
	assign in_stall = vld_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= pixel;
			ox_s1  <= origin_x;
			oy_s1  <= origin_y;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// ------------------------------------------------ placement and masking
	// Coordinates in modulo-2^COORD_W arithmetic; the top bit is the sign.
	logic [COORD_W-1:0] half_x, half_y, dx_c, dy_c;
	logic               x_in, y_in, emit_c;
	logic [PIXEL_W-1:0] val_c;

	always_comb begin
		half_x = draw_mode_q[MODE_CENTER] ? COORD_W'(eff_w >> 1) : '0;
		half_y = draw_mode_q[MODE_CENTER] ? COORD_W'(eff_h >> 1) : '0;
		dx_c = {{(COORD_W-ORIGIN_W){ox_s1[ORIGIN_W-1]}}, ox_s1}
			- half_x + COORD_W'(col_s1);
		dy_c = {{(COORD_W-ORIGIN_W){oy_s1[ORIGIN_W-1]}}, oy_s1}
			- half_y + COORD_W'(row_s1);

		// inside the frame and the clip window
		x_in = (dx_c[COORD_W-1:DEST_W] == '0)
			&& (dx_c[DEST_W-1:0] >= clip_left_q)
			&& (CLIP_HI_W'(dx_c[DEST_W-1:0]) < clip_right_q);
		y_in = (dy_c[COORD_W-1:DEST_W] == '0)
			&& (dy_c[DEST_W-1:0] >= clip_top_q)
			&& (CLIP_HI_W'(dy_c[DEST_W-1:0]) < clip_bottom_q);

		// transparency, blanking, bank remap
		val_c  = pix_s1;
		emit_c = 1'b1;
		if (pix_s1 == '0) begin
			emit_c = draw_mode_q[MODE_BLANK];
		end else if (draw_mode_q[MODE_COLOR] && (color_bank_q != '0)
			&& (pix_s1 < REMAP_LIMIT)) begin
			val_c = pix_s1 + {color_bank_q[3:0], 4'b0000};
		end
		emit_c = emit_c && x_in && y_in;
	end

	// ------------------------------------------------------ stage 2: result
	logic [DEST_W-1:0]  dx_s2, dy_s2;
	logic [PIXEL_W-1:0] val_s2;
	logic               vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1 && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && vld_s1 && emit_c) begin
			dx_s2  <= dx_c[DEST_W-1:0];
			dy_s2  <= dy_c[DEST_W-1:0];
			val_s2 <= val_c;
		end
	end

	assign out_valid = vld_s2;
	assign dest_x    = dx_s2;
	assign dest_y    = dy_s2;
	assign value     = val_s2;

	// ------------------------------------------------------------ assertions
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(col_q) < (CW+1)'(MAX_SPRITE_SIDE)
		&& (CW+1)'(row_q) < (CW+1)'(MAX_SPRITE_SIDE))
		else $error("sprite counter beyond maximum side");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !col_wrap |=> col_q == $past(col_q) + CW'(1))
		else $error("column counter failed to step");

	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && col_wrap) |=> $stable(row_q))
		else $error("row counter moved without column wrap");

	a_s1_keep: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !s2_free |=> vld_s1 && $stable(pix_s1) && $stable(col_s1))
		else $error("held input transaction lost");

	a_acc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> vld_s1)
		else $error("accepted transaction not registered");

endmodule
